FILE: rtl/core/odp_pkg.sv
package odp_pkg;

   // operation carried by one request word
   localparam logic OP_PIXEL       = 1'b0;
   localparam logic OP_GAMMA_WRITE = 1'b1;

   // configuration register indexes
   localparam logic CSR_DITHER_MODE      = 1'b0;
   localparam logic CSR_THREE_COMPONENTS = 1'b1;

   localparam int CSR_DATA_WIDTH = 2;

   // dither mode codes
   localparam logic [1:0] MODE_COLOUR = 2'd0;
   localparam logic [1:0] MODE_MONO   = 2'd1;
   localparam logic [1:0] MODE_GREY   = 2'd2;

   // register reset values
   localparam logic [1:0] DITHER_MODE_RESET      = MODE_COLOUR;
   localparam logic       THREE_COMPONENTS_RESET = 1'b1;

   // luminance weights, 0.59 / 0.20 / 0.11 in 256ths
   localparam logic [7:0] LUM_WEIGHT_R = 8'd151;
   localparam logic [7:0] LUM_WEIGHT_G = 8'd51;
   localparam logic [7:0] LUM_WEIGHT_B = 8'd28;

   localparam logic [3:0] GREY_TOP = 4'd15;

   typedef enum logic [1:0] {
      PATH_COLOUR,
      PATH_MONO,
      PATH_GREY
   } path_type;

   typedef struct packed {
      logic       op;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       end_of_row;
      logic       end_of_image;
      logic [7:0] gamma_address;
      logic [7:0] gamma_value;
   } req_type;

   typedef struct packed {
      logic       is_grey_level;
      logic [6:0] palette_index;
   } rsp_type;

   // 256-step threshold, index is column * 16 + row
   localparam logic [7:0] THR256 [256] = '{
      8'd0,8'd223,8'd48,8'd207,8'd14,8'd237,8'd62,8'd221,
      8'd3,8'd226,8'd51,8'd210,8'd13,8'd236,8'd61,8'd220,
      8'd175,8'd80,8'd128,8'd96,8'd189,8'd94,8'd141,8'd110,
      8'd178,8'd83,8'd130,8'd99,8'd188,8'd93,8'd140,8'd109,
      8'd191,8'd32,8'd239,8'd16,8'd205,8'd46,8'd253,8'd30,
      8'd194,8'd35,8'd242,8'd19,8'd204,8'd45,8'd252,8'd29,
      8'd112,8'd143,8'd64,8'd159,8'd126,8'd157,8'd78,8'd173,
      8'd115,8'd146,8'd67,8'd162,8'd125,8'd156,8'd77,8'd172,
      8'd11,8'd234,8'd59,8'd218,8'd5,8'd228,8'd53,8'd212,
      8'd8,8'd231,8'd56,8'd215,8'd6,8'd229,8'd54,8'd213,
      8'd186,8'd91,8'd138,8'd107,8'd180,8'd85,8'd132,8'd101,
      8'd183,8'd88,8'd135,8'd104,8'd181,8'd86,8'd133,8'd102,
      8'd202,8'd43,8'd250,8'd27,8'd196,8'd37,8'd244,8'd21,
      8'd199,8'd40,8'd247,8'd24,8'd197,8'd38,8'd245,8'd22,
      8'd123,8'd154,8'd75,8'd170,8'd117,8'd148,8'd69,8'd164,
      8'd120,8'd151,8'd72,8'd167,8'd118,8'd149,8'd70,8'd165,
      8'd12,8'd235,8'd60,8'd219,8'd2,8'd225,8'd50,8'd209,
      8'd15,8'd238,8'd63,8'd222,8'd1,8'd224,8'd49,8'd208,
      8'd187,8'd92,8'd139,8'd108,8'd177,8'd82,8'd129,8'd98,
      8'd190,8'd95,8'd142,8'd111,8'd176,8'd81,8'd128,8'd97,
      8'd203,8'd44,8'd251,8'd28,8'd193,8'd34,8'd241,8'd18,
      8'd206,8'd47,8'd254,8'd31,8'd192,8'd33,8'd240,8'd17,
      8'd124,8'd155,8'd76,8'd171,8'd114,8'd145,8'd66,8'd161,
      8'd127,8'd158,8'd79,8'd174,8'd113,8'd144,8'd65,8'd160,
      8'd7,8'd230,8'd55,8'd214,8'd9,8'd232,8'd57,8'd216,
      8'd4,8'd227,8'd52,8'd211,8'd10,8'd233,8'd58,8'd217,
      8'd182,8'd87,8'd134,8'd103,8'd184,8'd89,8'd136,8'd105,
      8'd179,8'd84,8'd131,8'd100,8'd185,8'd90,8'd137,8'd106,
      8'd198,8'd39,8'd246,8'd23,8'd200,8'd41,8'd248,8'd25,
      8'd195,8'd36,8'd243,8'd20,8'd201,8'd42,8'd249,8'd26,
      8'd119,8'd150,8'd71,8'd166,8'd121,8'd152,8'd73,8'd168,
      8'd116,8'd147,8'd68,8'd163,8'd122,8'd153,8'd74,8'd169
   };

   // 16-step threshold
   localparam logic [3:0] THR16 [256] = '{
      4'd0,4'd13,4'd3,4'd12,4'd1,4'd14,4'd4,4'd13,4'd0,4'd13,4'd3,4'd12,4'd1,4'd14,4'd4,4'd13,
      4'd10,4'd5,4'd8,4'd6,4'd11,4'd6,4'd8,4'd6,4'd10,4'd5,4'd8,4'd6,4'd11,4'd5,4'd8,4'd6,
      4'd11,4'd2,4'd14,4'd1,4'd12,4'd3,4'd15,4'd2,4'd11,4'd2,4'd14,4'd1,4'd12,4'd3,4'd15,4'd2,
      4'd7,4'd8,4'd4,4'd9,4'd7,4'd9,4'd5,4'd10,4'd7,4'd9,4'd4,4'd10,4'd7,4'd9,4'd5,4'd10,
      4'd1,4'd14,4'd3,4'd13,4'd0,4'd13,4'd3,4'd12,4'd0,4'd14,4'd3,4'd13,4'd0,4'd13,4'd3,4'd13,
      4'd11,4'd5,4'd8,4'd6,4'd11,4'd5,4'd8,4'd6,4'd11,4'd5,4'd8,4'd6,4'd11,4'd5,4'd8,4'd6,
      4'd12,4'd3,4'd15,4'd2,4'd12,4'd2,4'd14,4'd1,4'd12,4'd2,4'd15,4'd1,4'd12,4'd2,4'd14,4'd1,
      4'd7,4'd9,4'd4,4'd10,4'd7,4'd9,4'd4,4'd10,4'd7,4'd9,4'd4,4'd10,4'd7,4'd9,4'd4,4'd10,
      4'd1,4'd14,4'd4,4'd13,4'd0,4'd13,4'd3,4'd12,4'd1,4'd14,4'd4,4'd13,4'd0,4'd13,4'd3,4'd12,
      4'd11,4'd5,4'd8,4'd6,4'd10,4'd5,4'd8,4'd6,4'd11,4'd6,4'd8,4'd7,4'd10,4'd5,4'd8,4'd6,
      4'd12,4'd3,4'd15,4'd2,4'd11,4'd2,4'd14,4'd1,4'd12,4'd3,4'd15,4'd2,4'd11,4'd2,4'd14,4'd1,
      4'd7,4'd9,4'd4,4'd10,4'd7,4'd9,4'd4,4'd9,4'd7,4'd9,4'd5,4'd10,4'd7,4'd8,4'd4,4'd9,
      4'd0,4'd14,4'd3,4'd13,4'd1,4'd14,4'd3,4'd13,4'd0,4'd13,4'd3,4'd12,4'd1,4'd14,4'd3,4'd13,
      4'd11,4'd5,4'd8,4'd6,4'd11,4'd5,4'd8,4'd6,4'd11,4'd5,4'd8,4'd6,4'd11,4'd5,4'd8,4'd6,
      4'd12,4'd2,4'd14,4'd1,4'd12,4'd2,4'd15,4'd1,4'd11,4'd2,4'd14,4'd1,4'd12,4'd2,4'd15,4'd2,
      4'd7,4'd9,4'd4,4'd10,4'd7,4'd9,4'd4,4'd10,4'd7,4'd9,4'd4,4'd10,4'd7,4'd9,4'd4,4'd10
   };

   // 32-step threshold, green
   localparam logic [4:0] THR32 [256] = '{
      5'd0,5'd27,5'd6,5'd25,5'd2,5'd29,5'd8,5'd27,5'd0,5'd27,5'd6,5'd26,5'd2,5'd29,5'd7,5'd27,
      5'd21,5'd10,5'd16,5'd12,5'd23,5'd11,5'd17,5'd13,5'd22,5'd10,5'd16,5'd12,5'd23,5'd11,5'd17,5'd13,
      5'd23,5'd4,5'd29,5'd2,5'd25,5'd6,5'd31,5'd4,5'd24,5'd4,5'd29,5'd2,5'd25,5'd5,5'd31,5'd4,
      5'd14,5'd17,5'd8,5'd19,5'd15,5'd19,5'd9,5'd21,5'd14,5'd18,5'd8,5'd20,5'd15,5'd19,5'd9,5'd21,
      5'd1,5'd28,5'd7,5'd27,5'd1,5'd28,5'd6,5'd26,5'd1,5'd28,5'd7,5'd26,5'd1,5'd28,5'd7,5'd26,
      5'd23,5'd11,5'd17,5'd13,5'd22,5'd10,5'd16,5'd12,5'd22,5'd11,5'd16,5'd13,5'd22,5'd10,5'd16,5'd12,
      5'd25,5'd5,5'd30,5'd3,5'd24,5'd4,5'd30,5'd3,5'd24,5'd5,5'd30,5'd3,5'd24,5'd5,5'd30,5'd3,
      5'd15,5'd19,5'd9,5'd21,5'd14,5'd18,5'd8,5'd20,5'd15,5'd18,5'd9,5'd20,5'd14,5'd18,5'd8,5'd20,
      5'd1,5'd29,5'd7,5'd27,5'd0,5'd27,5'd6,5'd25,5'd2,5'd29,5'd8,5'd27,5'd0,5'd27,5'd6,5'd25,
      5'd23,5'd11,5'd17,5'd13,5'd22,5'd10,5'd16,5'd12,5'd23,5'd12,5'd17,5'd13,5'd21,5'd10,5'd16,5'd12,
      5'd25,5'd5,5'd31,5'd3,5'd23,5'd4,5'd29,5'd2,5'd25,5'd6,5'd31,5'd4,5'd23,5'd4,5'd29,5'd2,
      5'd15,5'd19,5'd9,5'd21,5'd14,5'd18,5'd8,5'd20,5'd15,5'd19,5'd10,5'd21,5'd14,5'd18,5'd8,5'd19,
      5'd1,5'd28,5'd7,5'd26,5'd1,5'd28,5'd7,5'd26,5'd0,5'd28,5'd6,5'd26,5'd1,5'd28,5'd7,5'd26,
      5'd22,5'd11,5'd16,5'd12,5'd22,5'd11,5'd17,5'd13,5'd22,5'd10,5'd16,5'd12,5'd23,5'd11,5'd17,5'd13,
      5'd24,5'd5,5'd30,5'd3,5'd24,5'd5,5'd30,5'd3,5'd24,5'd4,5'd30,5'd2,5'd24,5'd5,5'd30,5'd3,
      5'd14,5'd18,5'd9,5'd20,5'd15,5'd19,5'd9,5'd20,5'd14,5'd18,5'd8,5'd20,5'd15,5'd19,5'd9,5'd21
   };

   // 64-step threshold, red and blue
   localparam logic [5:0] THR64 [256] = '{
      6'd0,6'd55,6'd12,6'd51,6'd3,6'd59,6'd15,6'd55,6'd1,6'd56,6'd13,6'd52,6'd3,6'd58,6'd15,6'd54,
      6'd43,6'd20,6'd32,6'd24,6'd47,6'd23,6'd35,6'd27,6'd44,6'd20,6'd32,6'd24,6'd47,6'd23,6'd35,6'd27,
      6'd47,6'd8,6'd59,6'd4,6'd51,6'd11,6'd63,6'd7,6'd48,6'd9,6'd60,6'd5,6'd50,6'd11,6'd62,6'd7,
      6'd28,6'd35,6'd16,6'd39,6'd31,6'd39,6'd19,6'd43,6'd28,6'd36,6'd16,6'd40,6'd31,6'd39,6'd19,6'd43,
      6'd3,6'd58,6'd15,6'd54,6'd1,6'd56,6'd13,6'd52,6'd2,6'd57,6'd14,6'd53,6'd1,6'd57,6'd13,6'd53,
      6'd46,6'd22,6'd34,6'd26,6'd45,6'd21,6'd33,6'd25,6'd45,6'd22,6'd33,6'd26,6'd45,6'd21,6'd33,6'd25,
      6'd50,6'd11,6'd62,6'd7,6'd48,6'd9,6'd60,6'd5,6'd49,6'd10,6'd61,6'd6,6'd49,6'd9,6'd61,6'd5,
      6'd30,6'd38,6'd18,6'd42,6'd29,6'd37,6'd17,6'd41,6'd30,6'd37,6'd18,6'd41,6'd29,6'd37,6'd17,6'd41,
      6'd3,6'd58,6'd15,6'd54,6'd0,6'd56,6'd12,6'd52,6'd4,6'd59,6'd16,6'd55,6'd0,6'd55,6'd12,6'd51,
      6'd46,6'd23,6'd34,6'd27,6'd44,6'd20,6'd32,6'd24,6'd47,6'd23,6'd35,6'd27,6'd44,6'd20,6'd32,6'd24,
      6'd50,6'd11,6'd62,6'd7,6'd48,6'd8,6'd60,6'd4,6'd51,6'd12,6'd63,6'd8,6'd47,6'd8,6'd59,6'd4,
      6'd31,6'd38,6'd19,6'd42,6'd28,6'd36,6'd16,6'd40,6'd31,6'd39,6'd19,6'd43,6'd28,6'd36,6'd16,6'd40,
      6'd2,6'd57,6'd14,6'd53,6'd2,6'd57,6'd14,6'd53,6'd1,6'd56,6'd13,6'd52,6'd2,6'd58,6'd14,6'd54,
      6'd45,6'd21,6'd33,6'd25,6'd46,6'd22,6'd34,6'd26,6'd44,6'd21,6'd32,6'd25,6'd46,6'd22,6'd34,6'd26,
      6'd49,6'd10,6'd61,6'd6,6'd49,6'd10,6'd61,6'd6,6'd48,6'd9,6'd60,6'd5,6'd50,6'd10,6'd62,6'd6,
      6'd29,6'd37,6'd17,6'd41,6'd30,6'd38,6'd18,6'd42,6'd29,6'd36,6'd17,6'd40,6'd30,6'd38,6'd18,6'd42
   };

endpackage

FILE: rtl/core/odp_gamma_ram.sv
module odp_gamma_ram
   import odp_pkg::*;
(
   input  logic       clock,
   input  logic       wr_en,
   input  logic [7:0] wr_addr,
   input  logic [7:0] wr_data,
   input  logic       rd_en,
   input  logic [7:0] rd_addr,
   output logic [7:0] rd_data
);

   logic [7:0] mem_ff [256];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/odp_phase_counter.sv
module odp_phase_counter
   import odp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       end_of_row,
   input  logic       end_of_image,
   output logic [7:0] pos
);

   logic [3:0] column_ff, column_in;
   logic [3:0] row_ff, row_in;

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (step) begin
         priority if (end_of_image) begin
            column_in = '0;
            row_in    = '0;
         end else if (end_of_row) begin
            column_in = '0;
            row_in    = row_ff + 4'd1;
         end else begin
            column_in = column_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   // tile index: column in the high nibble
   assign pos = {column_ff, row_ff};

endmodule

FILE: rtl/core/odp_quantiser.sv
module odp_quantiser
   import odp_pkg::*;
(
   input  path_type   path,
   input  logic [7:0] pos,
   input  logic [7:0] value_a,
   input  logic [7:0] value_g,
   input  logic [7:0] value_b,
   output rsp_type    result
);

   logic [5:0] thr_rb;
   logic [4:0] thr_g;
   logic [3:0] thr_grey;
   logic [7:0] thr_mono;
   logic [1:0] level_r;
   logic [2:0] level_g;
   logic [1:0] level_b;
   logic [3:0] level_grey;

   always_comb begin
      thr_rb   = THR64[pos];
      thr_g    = THR32[pos];
      thr_grey = THR16[pos];
      thr_mono = THR256[pos];

      level_r = value_a[7:6];
      if (value_a[5:0] > thr_rb && value_a[7:6] != 2'd3) begin
         level_r = value_a[7:6] + 2'd1;
      end
      level_g = value_g[7:5];
      if (value_g[4:0] > thr_g && value_g[7:5] != 3'd7) begin
         level_g = value_g[7:5] + 3'd1;
      end
      level_b = value_b[7:6];
      if (value_b[5:0] > thr_rb && value_b[7:6] != 2'd3) begin
         level_b = value_b[7:6] + 2'd1;
      end
      level_grey = value_a[7:4];
      if (value_a[3:0] > thr_grey && value_a[7:4] != GREY_TOP) begin
         level_grey = value_a[7:4] + 4'd1;
      end

      unique case (path)
         PATH_COLOUR: begin
            result.is_grey_level = 1'b0;
            result.palette_index = {level_b, level_g, level_r};
         end
         PATH_MONO: begin
            result.is_grey_level = 1'b1;
            result.palette_index = (value_a < thr_mono) ? 7'd0 : {3'd0, GREY_TOP};
         end
         default: begin
            result.is_grey_level = 1'b1;
            result.palette_index = {3'd0, level_grey};
         end
      endcase
   end

endmodule

FILE: rtl/core/ordered_dither_palette_mapper_top.sv
// Ordered-dither palette mapper: pixels arrive in raster order on the req
// channel and each gives one rsp word, a 2:3:2 colour palette index or a
// grey level 0..15, dithered against a 16x16 threshold tile indexed by the
// pixel's column and row phase. A req word with op set to gamma write only
// loads one gamma table entry and gives no rsp word. The block takes one
// word per cycle while rsp_ready lets the tail advance; a pixel passes the
// input register, the registered gamma RAM read and the result register
// in turn before its result appears. The gamma table is held three times
// over so colour pixels can look up red, green and blue in the same cycle;
// its contents are undefined until written and there is no clearing pass
// after reset. The pipeline stalls only while a result waits on rsp_ready,
// though an empty input register can still take a word. Configuration may
// be changed only while the block is idle.
module ordered_dither_palette_mapper_top
   import odp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request words
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_word,
   // result words
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_word,
   // configuration writes
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_data
);

   // configuration registers
   logic [1:0] dither_mode_ff;
   logic       three_ff;

   // pipeline advances whenever the result register can take a word
   logic       advance;
   logic       req_fire;

   // stage a: registered request
   logic       a_vld_ff, a_vld_in;
   req_type    a_word_ff;
   logic [7:0] a_pos_ff;
   path_type   a_path_ff, a_path_in;

   // stage b: gamma RAM read data
   logic       b_vld_ff;
   logic [7:0] b_pos_ff;
   path_type   b_path_ff;

   // result register
   logic       rsp_vld_ff;
   rsp_type    rsp_word_ff;

   logic [7:0]  phase_pos;
   logic [15:0] lum_sum;
   logic [7:0]  addr_a;
   logic        gamma_wr;
   logic [7:0]  gamma_a;
   logic [7:0]  gamma_g;
   logic [7:0]  gamma_b;
   rsp_type     quant_result;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         dither_mode_ff <= DITHER_MODE_RESET;
         three_ff       <= THREE_COMPONENTS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DITHER_MODE:      dither_mode_ff <= csr_data[1:0];
            CSR_THREE_COMPONENTS: three_ff       <= csr_data[0];
            default:              ;
         endcase
      end
   end

   // ---------------- handshake ----------------
   assign advance   = !rsp_vld_ff || rsp_ready;
   // stage a can also refill while empty and the tail is stalled
   assign req_ready = advance || !a_vld_ff;
   assign req_fire  = req_valid && req_ready;

   // ---------------- tile phase ----------------
   odp_phase_counter u_phase (
      .clock        (clock),
      .reset        (reset),
      .step         (req_fire && req_word.op == OP_PIXEL),
      .end_of_row   (req_word.end_of_row),
      .end_of_image (req_word.end_of_image),
      .pos          (phase_pos)
   );

   // colour needs three components; mode three falls to grey
   always_comb begin
      if (dither_mode_ff == MODE_COLOUR && three_ff) begin
         a_path_in = PATH_COLOUR;
      end else if (dither_mode_ff == MODE_MONO) begin
         a_path_in = PATH_MONO;
      end else begin
         a_path_in = PATH_GREY;
      end
      a_vld_in = req_ready ? req_valid : a_vld_ff;
   end

   // ---------------- stage a ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
      end
      if (req_fire) begin
         a_word_ff <= req_word;
         a_pos_ff  <= phase_pos;
         a_path_ff <= a_path_in;
      end
   end

   // luminance (151r + 51g + 28b) >> 8
   assign lum_sum = {8'd0, a_word_ff.red}   * {8'd0, LUM_WEIGHT_R}
                  + {8'd0, a_word_ff.green} * {8'd0, LUM_WEIGHT_G}
                  + {8'd0, a_word_ff.blue}  * {8'd0, LUM_WEIGHT_B};

   // first copy reads red in colour or single-component mode, otherwise the luminance sample
   assign addr_a = (a_path_ff == PATH_COLOUR || !three_ff) ? a_word_ff.red
                                                            : lum_sum[15:8];

   assign gamma_wr = a_vld_ff && advance && a_word_ff.op == OP_GAMMA_WRITE;

   // three identical copies of the gamma table, one read port each
   odp_gamma_ram u_gamma_a (
      .clock   (clock),
      .wr_en   (gamma_wr),
      .wr_addr (a_word_ff.gamma_address),
      .wr_data (a_word_ff.gamma_value),
      .rd_en   (advance),
      .rd_addr (addr_a),
      .rd_data (gamma_a)
   );

   odp_gamma_ram u_gamma_g (
      .clock   (clock),
      .wr_en   (gamma_wr),
      .wr_addr (a_word_ff.gamma_address),
      .wr_data (a_word_ff.gamma_value),
      .rd_en   (advance),
      .rd_addr (a_word_ff.green),
      .rd_data (gamma_g)
   );

   odp_gamma_ram u_gamma_b (
      .clock   (clock),
      .wr_en   (gamma_wr),
      .wr_addr (a_word_ff.gamma_address),
      .wr_data (a_word_ff.gamma_value),
      .rd_en   (advance),
      .rd_addr (a_word_ff.blue),
      .rd_data (gamma_b)
   );

   // ---------------- stage b ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (advance) begin
         // gamma writes drop out here
         b_vld_ff <= a_vld_ff && a_word_ff.op == OP_PIXEL;
      end
      if (advance) begin
         b_pos_ff  <= a_pos_ff;
         b_path_ff <= a_path_ff;
      end
   end

   odp_quantiser u_quant (
      .path    (b_path_ff),
      .pos     (b_pos_ff),
      .value_a (gamma_a),
      .value_g (gamma_g),
      .value_b (gamma_b),
      .result  (quant_result)
   );

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= b_vld_ff;
      end
      if (advance) begin
         rsp_word_ff <= quant_result;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   // grey results never exceed level 15
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.is_grey_level |-> rsp_word.palette_index[6:4] == 3'd0)
      else $error("grey level out of range");

   // a gamma write leaving stage a never becomes a result
   assert property (@(posedge clock) disable iff (reset)
      gamma_wr |=> !b_vld_ff)
      else $error("gamma write produced a result");

   // a pixel held in stage b is not lost while the tail stalls
   assert property (@(posedge clock) disable iff (reset)
      b_vld_ff && !advance |=> b_vld_ff)
      else $error("stalled pixel dropped");

   // end of image returns the tile phase to its origin
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_word.op == OP_PIXEL && req_word.end_of_image |=> phase_pos == 8'd0)
      else $error("phase not cleared at end of image");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import odp_pkg::*;

   // timing of the run
   localparam int SETTLE_CYCLES = 8;       // pipeline is three deep, plus margin
   localparam int CYCLE_LIMIT   = 400000;  // far beyond the slowest correct run
   localparam int PHASE_WORDS   = 130;     // random words per configuration

   // dither mode code the block does not name, handled as grey
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // block ports
   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_ready;
   req_type                   req_word         = '0;
   logic                      rsp_valid;
   logic                      rsp_ready        = 1'b1;
   rsp_type                   rsp_word;
   logic                      csr_write_enable = 1'b0;
   logic                      csr_index        = 1'b0;
   logic [CSR_DATA_WIDTH-1:0] csr_data         = '0;

   // own copy of the block's state, updated as each word is accepted
   logic [7:0] gamma_shadow [256];
   logic [3:0] column_phase = 4'd0;
   logic [3:0] row_phase    = 4'd0;
   logic [1:0] model_mode   = DITHER_MODE_RESET;
   logic       model_three  = THREE_COMPONENTS_RESET;

   // results still owed by the block, oldest first
   rsp_type palette_queue [$];
   rsp_type wanted;

   int error_count = 0;
   int cycle_count = 0;
   int stall_style = 0;

   ordered_dither_palette_mapper_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // receiver back-pressure, the style is redrawn at random periodically
   // so that long open stretches alternate with heavy stalling
   always @(posedge clock) begin
      if (cycle_count % 200 == 0) stall_style = $urandom_range(0, 3);
      case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (cycle_count[3:0] < 4'd11);
      endcase
   end

   task automatic report_mismatch(input string what, input int want_val, input int got_val);
      $display("mismatch at cycle %0d: %s expected %0d got %0d",
               cycle_count, what, want_val, got_val);
      error_count++;
   endtask

   // one dither step: keep the top bits, bump by one when the dropped bits
   // beat the threshold, but never past the top level
   function automatic int quantise_level(input int value, input int drop, input int thr);
      int level;
      int rest;
      level = value >> drop;
      rest  = value & ((1 << drop) - 1);
      if (rest > thr && level < (255 >> drop)) level++;
      return level;
   endfunction

   // predicts the result of one accepted word and advances the tile phases
   task automatic predict_palette(input req_type w);
      logic [7:0] pos;
      int         lum;
      int         level;
      rsp_type    result;
      if (w.op == OP_GAMMA_WRITE) begin
         // table load only, no result and the phases stay put
         gamma_shadow[w.gamma_address] = w.gamma_value;
         return;
      end
      pos = {column_phase, row_phase};
      if (model_three)
         lum = (151 * int'(w.red) + 51 * int'(w.green) + 28 * int'(w.blue)) >> 8;
      else
         lum = int'(w.red);
      lum = int'(gamma_shadow[lum[7:0]]);
      if (model_mode == MODE_COLOUR && model_three) begin
         // 2:3:2 palette, each sample through the gamma table on its own
         level = quantise_level(int'(gamma_shadow[w.red]), 6, int'(THR64[pos]))
               | (quantise_level(int'(gamma_shadow[w.green]), 5, int'(THR32[pos])) << 2)
               | (quantise_level(int'(gamma_shadow[w.blue]), 6, int'(THR64[pos])) << 5);
         result.is_grey_level = 1'b0;
      end else if (model_mode == MODE_MONO) begin
         level = (lum < int'(THR256[pos])) ? 0 : 15;
         result.is_grey_level = 1'b1;
      end else begin
         // grey mode, also single-component colour and the unused mode code
         level = quantise_level(lum, 4, int'(THR16[pos]));
         result.is_grey_level = 1'b1;
      end
      result.palette_index = level[6:0];
      palette_queue.push_back(result);
      // end of image wins over end of row
      if (w.end_of_image) begin
         column_phase = 4'd0;
         row_phase    = 4'd0;
      end else if (w.end_of_row) begin
         column_phase = 4'd0;
         row_phase    = row_phase + 4'd1;
      end else begin
         column_phase = column_phase + 4'd1;
      end
   endtask

   // result checker: every accepted rsp word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (palette_queue.size() == 0) begin
            report_mismatch("unexpected rsp word, index", 0, int'(rsp_word.palette_index));
         end else begin
            wanted = palette_queue.pop_front();
            if (rsp_word.is_grey_level !== wanted.is_grey_level)
               report_mismatch("is_grey_level", int'(wanted.is_grey_level),
                               int'(rsp_word.is_grey_level));
            if (rsp_word.palette_index !== wanted.palette_index)
               report_mismatch("palette_index", int'(wanted.palette_index),
                               int'(rsp_word.palette_index));
         end
      end
   end

   // valid is left high on return so that back-to-back words need no bubble
   task automatic send_word(input req_type w);
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_palette(w);
   endtask

   function automatic req_type random_word();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic eor, input logic eoi);
      req_type w;
      w              = random_word();
      w.op           = OP_PIXEL;
      w.red          = r;
      w.green        = g;
      w.blue         = b;
      w.end_of_row   = eor;
      w.end_of_image = eoi;
      send_word(w);
   endtask

   // idle the sender until every result is back and any gamma write has
   // drained out of the pipeline
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (palette_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_DITHER_MODE) model_mode = data;
      else model_three = data[0];
      @(posedge clock);
   endtask

   // upper data bit is random on the one-bit register, the block must drop it
   task automatic set_config(input logic [1:0] mode, input logic three);
      wait_for_results();
      write_csr(CSR_DITHER_MODE, mode);
      write_csr(CSR_THREE_COMPONENTS, {1'($urandom), three});
   endtask

   // fill every gamma entry before any pixel reads it; ends pinned to 0 and 255
   task automatic test_gamma_load();
      req_type w;
      for (int i = 0; i < 256; i++) begin
         w               = random_word();
         w.op            = OP_GAMMA_WRITE;
         w.gamma_address = i[7:0];
         if (i == 0) w.gamma_value = 8'd0;
         else if (i == 255) w.gamma_value = 8'd255;
         send_word(w);
      end
   endtask

   // colour extremes under the reset configuration, saturation at top levels
   task automatic test_colour_extremes();
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b1, 1'b0);
   endtask

   // row end, image end, and both flags on one pixel
   task automatic test_phase_flags();
      send_pixel(8'd128, 8'd64, 8'd32, 1'b1, 1'b0);
      send_pixel(8'd200, 8'd100, 8'd50, 1'b0, 1'b1);
      send_pixel(8'd77, 8'd177, 8'd7, 1'b1, 1'b1);
   endtask

   task automatic test_dither_modes();
      set_config(MODE_MONO, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
      send_pixel(8'd128, 8'd128, 8'd128, 1'b1, 1'b0);
      set_config(MODE_GREY, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
      // single component: green and blue must not matter
      set_config(MODE_GREY, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd255, 1'b0, 1'b0);
      // single-component colour falls back to grey levels
      set_config(MODE_COLOUR, 1'b0);
      send_pixel(8'd255, 8'd17, 8'd99, 1'b0, 1'b0);
      send_pixel(8'd93, 8'd255, 8'd0, 1'b0, 1'b1);
      set_config(MODE_UNUSED, 1'b1);
      send_pixel(8'd180, 8'd40, 8'd220, 1'b0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
   endtask

   // mostly well-formed images (rows past 16 pixels, images past 16 rows)
   // with a sprinkling of gamma writes and stray row/image flags
   task automatic run_random_phase(input logic [1:0] mode, input logic three);
      req_type w;
      int sent;
      int burst_left;
      int gap;
      int col_pos;
      int row_len;
      int rows_left;
      set_config(mode, three);
      sent       = 0;
      burst_left = $urandom_range(1, 30);
      col_pos    = 0;
      row_len    = $urandom_range(1, 40);
      rows_left  = $urandom_range(1, 20);
      while (sent < PHASE_WORDS) begin
         w = random_word();
         if ($urandom_range(0, 9) == 0) begin
            w.op = OP_GAMMA_WRITE;
         end else begin
            w.op = OP_PIXEL;
            if ($urandom_range(0, 19) != 0) begin
               col_pos++;
               w.end_of_row   = (col_pos >= row_len);
               w.end_of_image = 1'b0;
               if (w.end_of_row) begin
                  col_pos   = 0;
                  row_len   = $urandom_range(1, 40);
                  rows_left = rows_left - 1;
                  if (rows_left == 0) begin
                     w.end_of_image = 1'b1;
                     rows_left      = $urandom_range(1, 20);
                  end
               end
            end
         end
         send_word(w);
         sent++;
         // sender holds off mid-phase until the block has emptied
         if (sent == PHASE_WORDS / 2) wait_for_results();
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   task automatic test_random_stream();
      run_random_phase(MODE_COLOUR, 1'b1);
      run_random_phase(MODE_MONO, 1'b1);
      run_random_phase(MODE_GREY, 1'b1);
      run_random_phase(MODE_UNUSED, 1'b1);
      run_random_phase(MODE_COLOUR, 1'b0);
      run_random_phase(MODE_MONO, 1'b0);
      run_random_phase(MODE_GREY, 1'b0);
      run_random_phase(MODE_UNUSED, 1'b0);
      run_random_phase(MODE_COLOUR, 1'b1);
   endtask

   initial begin
      // synchronous reset asserted once at the start, then released
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_gamma_load();
      test_colour_extremes();
      test_phase_flags();
      test_dither_modes();
      test_random_stream();
      wait_for_results();
      if (error_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
